FILE: design/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 4;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_REAR  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_REAR   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
    } t_cell_ctl;

endpackage

FILE: design/cdq_req_if.sv
// ----------------------------------------------------------------------------
// cdq_req_if
// Request channel: command and data word with valid/ready.
// ----------------------------------------------------------------------------
interface cdq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic signed [31:0] data_in;

    modport source (output valid, output command, output data_in, input ready);
    modport sink   (input valid, input command, input data_in, output ready);
endinterface

FILE: design/cdq_rsp_if.sv
// ----------------------------------------------------------------------------
// cdq_rsp_if
// Response channel: popped word, status and occupancy with valid/ready.
// ----------------------------------------------------------------------------
interface cdq_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] data_out;
    logic [1:0]  status;
    logic [3:0]  occupancy;

    modport source (output valid, output data_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input data_out, input status, input occupancy,
                    output ready);
endinterface

FILE: design/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell
// One queue slot. Shifts toward the rear on push front, toward the front on
// pop front, and loads the request word on push rear when it is the next
// free slot. Presents its word as the rear tap when it is the last occupied slot.
// ----------------------------------------------------------------------------
module cdq_cell #(
    parameter int CW  = 4,
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  cdq_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]      i_count,
    input  cdq_pkg::t_word     i_data,
    input  cdq_pkg::t_word     i_left,
    input  cdq_pkg::t_word     i_right,
    output cdq_pkg::t_word     o_word,
    output cdq_pkg::t_word     o_tap
);
    import cdq_pkg::*;

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_front) begin
            r_word <= i_left;
        end else if (i_ctl.push_rear && (i_count == CW'(IDX))) begin
            r_word <= i_data;
        end else if (i_ctl.pop_front) begin
            r_word <= i_right;
        end
    end

    assign o_word = r_word;
    assign o_tap  = (i_count == CW'(IDX + 1)) ? r_word : '0;

endmodule

FILE: design/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Fill count, full/empty checks, cell controls and the response register.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
    parameter int DEPTH = 8,
    parameter int CW    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_command,
    input  cdq_pkg::t_word         i_front_word,
    input  cdq_pkg::t_word         i_rear_word,
    output cdq_pkg::t_cell_ctl     o_ctl,
    output logic [CW-1:0]          o_count,
    output logic                   o_valid,
    input  logic                   i_ready,
    output cdq_pkg::t_word         o_data,
    output logic [1:0]             o_status,
    output logic [cdq_pkg::OCC_W-1:0] o_occ
);
    import cdq_pkg::*;

    logic [CW-1:0]    r_count, n_count;
    logic             r_valid, n_valid;
    t_word            r_data, n_data;
    t_status          r_status, n_status;
    logic [OCC_W-1:0] r_occ, n_occ;

    logic accept, is_push, is_full, is_empty;
    t_cmd cmd;

    assign cmd      = t_cmd'(i_command);
    assign o_ready  = !r_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        o_ctl    = '0;
        n_count  = r_count;
        n_valid  = r_valid && !i_ready;
        n_data   = r_data;
        n_status = r_status;
        n_occ    = r_occ;
        if (accept) begin
            n_valid  = 1'b1;
            n_data   = '0;
            n_status = ST_DONE;
            unique case (cmd) inside
                CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_ctl.push_front = (cmd == CMD_PUSH_FRONT);
                        o_ctl.push_rear  = (cmd == CMD_PUSH_REAR);
                        n_count          = r_count + CW'(1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_REAR: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        o_ctl.pop_front = (cmd == CMD_POP_FRONT);
                        n_data  = (cmd == CMD_POP_FRONT) ? i_front_word : i_rear_word;
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
            n_occ = OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_status <= n_status;
        r_occ    <= n_occ;
    end

    assign o_count  = r_count;
    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_occ    = r_occ;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_push && is_full |=> r_status == ST_FULL && $stable(r_count))
        else $error("push into full queue not refused");

    a_empty_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !is_push && is_empty |=> r_status == ST_EMPTY && r_count == '0)
        else $error("pop from empty queue not refused");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != ST_DONE |-> r_data == '0)
        else $error("refused request carries data");

    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_occ == OCC_W'(r_count))
        else $error("reported occupancy differs from count");

endmodule

FILE: design/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH signed words held in a chain of slot cells,
// front word in the first cell. Push and pop at either end, with full and
// empty refusals reported in the response status.
//
//   channel  dir  fields                          handshake
//   i_req    in   command, data_in                valid/ready
//   o_rsp    out  data_out, status, occupancy     valid/ready
//
// One request per cycle while responses drain, answered the next cycle.
// The request side stays ready while the response register is empty or
// being drained, so a stalled response holds off only the next request.
// Reset clears the fill count and the response valid; slot contents are
// left as they are and are never read before written.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cdq_req_if.sink      i_req,
    cdq_rsp_if.source    o_rsp
);
    import cdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_cell_ctl     ctl;
    logic [CW-1:0] count;
    t_word         word  [DEPTH];
    t_word         tap   [DEPTH];
    t_word         left  [DEPTH];
    t_word         right [DEPTH];
    t_word         rear_word;
    t_word         data_out;
    logic [1:0]    status;
    logic [OCC_W-1:0] occ;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign left[g] = i_req.data_in;
            end else begin : g_mid
                assign left[g] = word[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right[g] = word[g];
            end else begin : g_inner
                assign right[g] = word[g+1];
            end
            cdq_cell #(
                .CW  (CW),
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_count (count),
                .i_data  (i_req.data_in),
                .i_left  (left[g]),
                .i_right (right[g]),
                .o_word  (word[g]),
                .o_tap   (tap[g])
            );
        end
    endgenerate

    // rear word: only the last occupied slot drives its tap
    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_word = rear_word | tap[i];
        end
    end

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .o_ready      (i_req.ready),
        .i_command    (i_req.command),
        .i_front_word (word[0]),
        .i_rear_word  (rear_word),
        .o_ctl        (ctl),
        .o_count      (count),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_data       (data_out),
        .o_status     (status),
        .o_occ        (occ)
    );

    assign o_rsp.data_out  = data_out;
    assign o_rsp.status    = status;
    assign o_rsp.occupancy = occ;

endmodule

FILE: bench/cdq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdq_checker
// Watches the request and response channels of the double-ended queue,
// keeps its own ring model of the queue and compares every response, field
// by field, with the oldest predicted one. The failure and pending counts go
// to the testbench top.
// ----------------------------------------------------------------------------
module cdq_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cdq_req_if   i_req,
    cdq_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_compared,
    output int   o_full_refusals,
    output int   o_empty_refusals
);
    import cdq_pkg::*;

    localparam int DEPTH = 8;
    localparam int IX_W  = $clog2(DEPTH);

    typedef struct packed {
        t_word            data;
        t_status          st;
        logic [OCC_W-1:0] occ;
    } t_deque_result;

    t_word           ring [DEPTH];
    logic [IX_W-1:0] head_ix;
    logic [IX_W-1:0] tail_ix;
    logic            is_empty;
    t_deque_result   expected_q [$];
    int              fails     = 0;
    int              compared  = 0;
    int              full_cnt  = 0;
    int              empty_cnt = 0;

    // ring of a power-of-two size, so indices wrap by their width
    function automatic t_deque_result deque_apply(input t_cmd cmd, input t_word word);
        t_deque_result r;
        logic          full;
        r.data = '0;
        r.st   = ST_DONE;
        full   = !is_empty && (IX_W'(tail_ix + 1'b1) == head_ix);
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
            if (full) begin
                r.st = ST_FULL;
            end else if (is_empty) begin
                head_ix  = '0;
                tail_ix  = '0;
                is_empty = 1'b0;
                ring[0]  = word;
            end else if (cmd == CMD_PUSH_FRONT) begin
                head_ix       = head_ix - 1'b1;
                ring[head_ix] = word;
            end else begin
                tail_ix       = tail_ix + 1'b1;
                ring[tail_ix] = word;
            end
        end else if (is_empty) begin
            r.st = ST_EMPTY;
        end else begin
            r.data = (cmd == CMD_POP_FRONT) ? ring[head_ix] : ring[tail_ix];
            if (head_ix == tail_ix) begin
                is_empty = 1'b1;
                head_ix  = '0;
                tail_ix  = '0;
            end else if (cmd == CMD_POP_FRONT) begin
                head_ix = head_ix + 1'b1;
            end else begin
                tail_ix = tail_ix - 1'b1;
            end
        end
        r.occ = is_empty ? '0 : OCC_W'(IX_W'(tail_ix - head_ix)) + 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            head_ix  = '0;
            tail_ix  = '0;
            is_empty = 1'b1;
            expected_q.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                want = deque_apply(t_cmd'(i_req.command), i_req.data_in);
                if (want.st == ST_FULL) full_cnt++;
                if (want.st == ST_EMPTY) empty_cnt++;
                expected_q.push_back(want);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_q.size() == 0) begin
                    $error("response with no request outstanding");
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    compared++;
                    if (i_rsp.data_out !== want.data) begin
                        $error("data_out mismatch: expected %0d, actual %0d",
                               want.data, i_rsp.data_out);
                        fails++;
                    end
                    if (i_rsp.status !== want.st) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.st, i_rsp.status);
                        fails++;
                    end
                    if (i_rsp.occupancy !== want.occ) begin
                        $error("occupancy mismatch: expected %0d, actual %0d",
                               want.occ, i_rsp.occupancy);
                        fails++;
                    end
                end
            end
        end
        o_fail_count     <= fails;
        o_pending        <= expected_q.size();
        o_compared       <= compared;
        o_full_refusals  <= full_cnt;
        o_empty_refusals <= empty_cnt;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the double-ended queue: a directed opening that hits
// both ends, wraparound, full and empty refusals and the data extremes, then
// random requests with a drifting push/pop mix so the queue swings between
// empty and full. Both channels idle in random bursts, the receiver holds
// off once for a long stretch, and the last part runs without gaps.
// ----------------------------------------------------------------------------
module tb;
    import cdq_pkg::*;

    localparam int RANDOM_REQUESTS = 800;
    localparam int HOLD_CYCLES     = 80;
    localparam int CYCLE_LIMIT     = 200000;

    logic clk;
    logic rst_n;
    bit   gaps_on   = 1'b1;
    bit   long_hold = 1'b0;
    int   cycles    = 0;
    int   requests  = 0;
    int   fail_count;
    int   pending;
    int   compared;
    int   full_refusals;
    int   empty_refusals;

    cdq_req_if req_ch ();
    cdq_rsp_if rsp_ch ();

    circular_deque #(
        .DEPTH(8)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    cdq_checker chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req           (req_ch),
        .i_rsp           (rsp_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_compared      (compared),
        .o_full_refusals (full_refusals),
        .o_empty_refusals(empty_refusals)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // response side: random stalls, plus one long hold on request
    initial begin
        forever begin
            if (long_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic issue_request(input t_cmd cmd, input t_word word);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.data_in <= word;
        do @(posedge clk); while (!req_ch.ready);
        requests++;
    endtask

    initial begin
        t_cmd cmd;
        int   push_pct;
        push_pct       = 50;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_PUSH_FRONT;
        req_ch.data_in <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty refusals, single-word round trips
        issue_request(CMD_POP_FRONT, 32'sd0);
        issue_request(CMD_POP_REAR, 32'sd0);
        issue_request(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        issue_request(CMD_POP_FRONT, 32'sd0);
        issue_request(CMD_PUSH_REAR, 32'sh8000_0000);
        issue_request(CMD_POP_REAR, 32'sd0);
        // fill from both ends, wrapping the front index
        issue_request(CMD_PUSH_FRONT, 32'sh8000_0000);
        issue_request(CMD_PUSH_REAR, 32'sh7FFF_FFFF);
        issue_request(CMD_PUSH_FRONT, -32'sd1);
        issue_request(CMD_PUSH_REAR, 32'sd0);
        issue_request(CMD_PUSH_FRONT, 32'sd1);
        issue_request(CMD_PUSH_REAR, 32'sh5555_5555);
        issue_request(CMD_PUSH_FRONT, 32'shAAAA_AAAA);
        issue_request(CMD_PUSH_REAR, 32'sd12345);
        // full refusals
        issue_request(CMD_PUSH_FRONT, 32'sh1234_5678);
        issue_request(CMD_PUSH_REAR, -32'sd7);
        // drain from both ends
        repeat (4) begin
            issue_request(CMD_POP_FRONT, $urandom);
            issue_request(CMD_POP_REAR, $urandom);
        end
        issue_request(CMD_POP_REAR, 32'sd0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            if (n == 300) long_hold = 1'b1;
            if (n == 650) gaps_on = 1'b0;
            if ($urandom_range(0, 99) < push_pct) begin
                cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
            end else begin
                cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
            end
            issue_request(cmd, $urandom);
        end

        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (5) @(posedge clk);

        $display("%0d requests sent, %0d responses checked against the queue model",
                 requests, compared);
        $display("%0d pushes refused as full, %0d pops refused as empty",
                 full_refusals, empty_refusals);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
